[rtl/chacha20_stream_cipher_core_defines.svh]
// Assertion macros used by the cipher core RTL.
`ifndef CHACHA20_STREAM_CIPHER_CORE_DEFINES_SVH
`define CHACHA20_STREAM_CIPHER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// cond must never hold
`define CC20_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
// ante implies cons in the same cycle
`define CC20_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// ante implies cons in the next cycle
`define CC20_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CC20_ASSERT_NEVER(label, clk, rst, cond, msg)
`define CC20_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define CC20_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

[rtl/cc20_pkg.sv]
// Shared types, constants and quarter-round functions of the ChaCha20 core.
package cc20_pkg;

   localparam int DOUBLE_ROUNDS_DEFAULT = 10;
   localparam int QUEUE_DEPTH           = 4;
   localparam int CSR_ADDR_W            = 6;
   localparam int CSR_DATA_W            = 64;
   localparam int POS_W                 = 6;

   typedef logic [31:0]       word_type;
   typedef logic [15:0][31:0] block_type;
   typedef logic [3:0][31:0]  quad_type;

   // "expand 32-byte k", word 0 in the low slot
   localparam quad_type SIGMA = {32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865};

   typedef struct packed {
      logic [7:0][31:0] key;
      logic [2:0][31:0] nonce;
      logic [31:0]      init_ctr;
   } cfg_type;

   typedef struct packed {
      logic [7:0]       data_byte;
      logic             end_of_message;
      logic [POS_W-1:0] pos;
      logic [31:0]      ctr;
   } item_type;

   typedef struct packed {
      logic        start;
      logic        abort;
      logic [31:0] ctr;
   } gen_ctrl_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [31:0] ctr;
   } gen_status_type;

   function automatic block_type init_state(cfg_type cfg, word_type ctr);
      block_type s;
      s[3:0]   = SIGMA;
      s[11:4]  = cfg.key;
      s[12]    = ctr;
      s[15:13] = cfg.nonce;
      return s;
   endfunction

   // first half of a quarter round: q = {d, c, b, a}
   function automatic quad_type qr_first(quad_type q);
      word_type a;
      word_type b;
      word_type c;
      word_type d;
      word_type t;
      a = q[0] + q[1];
      t = q[3] ^ a;
      d = {t[15:0], t[31:16]};
      c = q[2] + d;
      t = q[1] ^ c;
      b = {t[19:0], t[31:20]};
      return {d, c, b, a};
   endfunction

   function automatic quad_type qr_second(quad_type q);
      word_type a;
      word_type b;
      word_type c;
      word_type d;
      word_type t;
      a = q[0] + q[1];
      t = q[3] ^ a;
      d = {t[23:0], t[31:24]};
      c = q[2] + d;
      t = q[1] ^ c;
      b = {t[24:0], t[31:25]};
      return {d, c, b, a};
   endfunction

endpackage

[rtl/cc20_fifo.sv]
// Short request queue between the front and back halves.
module cc20_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  cc20_pkg::item_type  push_item,
   input  logic                pop,
   output logic                full,
   output logic                empty,
   output cc20_pkg::item_type  head
);
   import cc20_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam logic [PTR_W:0] DEPTH_COUNT = (PTR_W + 1)'(QUEUE_DEPTH);

   item_type         mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W:0]   count_ff;

   assign full  = (count_ff == DEPTH_COUNT);
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[rtl/cc20_front.sv]
// Request intake: tracks message start, byte position and block counter.
module cc20_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_data_byte,
   input  logic                req_end_of_message,
   input  logic [31:0]         init_ctr,
   input  logic                full,
   output logic                push,
   output cc20_pkg::item_type  item
);
   import cc20_pkg::*;

   logic             msg_start_ff;
   logic             msg_start_in;
   logic [POS_W-1:0] pos_ff;
   logic [POS_W-1:0] pos_in;
   word_type         ctr_ff;
   word_type         ctr_in;
   logic [POS_W-1:0] eff_pos;
   word_type         eff_ctr;

   always_comb begin
      eff_pos   = msg_start_ff ? '0 : pos_ff;
      eff_ctr   = msg_start_ff ? init_ctr : ctr_ff;
      req_ready = !full;
      push      = req_valid && !full;

      item.data_byte      = req_data_byte;
      item.end_of_message = req_end_of_message;
      item.pos            = eff_pos;
      item.ctr            = eff_ctr;

      msg_start_in = msg_start_ff;
      pos_in       = pos_ff;
      ctr_in       = ctr_ff;
      if (push) begin
         msg_start_in = req_end_of_message;
         pos_in       = req_end_of_message ? '0 : eff_pos + 1'b1;
         // counter steps after the last byte of a block, wrapping
         ctr_in       = (eff_pos == {POS_W{1'b1}}) ? eff_ctr + 32'd1 : eff_ctr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         msg_start_ff <= 1'b1;
         pos_ff       <= '0;
         ctr_ff       <= '0;
      end else begin
         msg_start_ff <= msg_start_in;
         pos_ff       <= pos_in;
         ctr_ff       <= ctr_in;
      end
   end

endmodule

[rtl/cc20_core.sv]
// Keystream block generator: shared round unit plus feed-forward.
module cc20_core #(
   parameter int DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cc20_pkg::cfg_type        cfg,
   input  cc20_pkg::gen_ctrl_type   ctrl,
   output cc20_pkg::gen_status_type status,
   output cc20_pkg::block_type      block_out
);
   import cc20_pkg::*;

   // four steps per double round: column halves, then diagonal halves
   localparam int STEPS  = 4 * DOUBLE_ROUNDS;
   localparam int STEP_W = $clog2(STEPS + 1);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS);

   logic              busy_ff;
   logic [STEP_W-1:0] step_ff;
   word_type          ctr_ff;
   block_type         x_ff;
   block_type         x_in;
   block_type         start_state;
   block_type         feed_state;
   logic              half_sel;
   logic              diag_sel;
   logic              last;

   assign half_sel    = step_ff[0];
   assign diag_sel    = step_ff[1];
   assign last        = (step_ff == LAST_STEP);
   assign start_state = init_state(cfg, ctrl.ctr);
   assign feed_state  = init_state(cfg, ctr_ff);

   always_comb begin
      quad_type q;
      quad_type r;
      x_in = x_ff;
      for (int i = 0; i < 4; i++) begin
         if (diag_sel) begin
            q = {x_ff[12 + ((i + 3) & 3)], x_ff[8 + ((i + 2) & 3)],
                 x_ff[4 + ((i + 1) & 3)], x_ff[i]};
         end else begin
            q = {x_ff[12 + i], x_ff[8 + i], x_ff[4 + i], x_ff[i]};
         end
         r = half_sel ? qr_second(q) : qr_first(q);
         if (diag_sel) begin
            x_in[i]                  = r[0];
            x_in[4 + ((i + 1) & 3)]  = r[1];
            x_in[8 + ((i + 2) & 3)]  = r[2];
            x_in[12 + ((i + 3) & 3)] = r[3];
         end else begin
            x_in[i]      = r[0];
            x_in[4 + i]  = r[1];
            x_in[8 + i]  = r[2];
            x_in[12 + i] = r[3];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         block_out[i] = x_ff[i] + feed_state[i];
      end
      status.busy = busy_ff;
      status.done = busy_ff && last;
      status.ctr  = ctr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else if (ctrl.abort) begin
         busy_ff <= 1'b0;
      end else if (ctrl.start) begin
         busy_ff <= 1'b1;
         step_ff <= '0;
      end else if (busy_ff) begin
         if (last) begin
            busy_ff <= 1'b0;
         end else begin
            step_ff <= step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         x_ff   <= start_state;
         ctr_ff <= ctrl.ctr;
      end else if (busy_ff && !last) begin
         x_ff <= x_in;
      end
   end

endmodule

[rtl/cc20_back.sv]
// Execution half: keystream buffers, prefetch control, XOR and result register.
`include "chacha20_stream_cipher_core_defines.svh"
module cc20_back #(
   parameter int DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  cc20_pkg::cfg_type   cfg,
   input  logic                cfg_wr,
   input  logic                head_valid,
   input  cc20_pkg::item_type  head,
   output logic                head_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_last_out
);
   import cc20_pkg::*;

   gen_ctrl_type   gen_ctrl;
   gen_status_type gen_status;
   block_type      gen_block;

   block_type cur_ff;
   word_type  cur_tag_ff;
   logic      cur_valid_ff;
   block_type nxt_ff;
   word_type  nxt_tag_ff;
   logic      nxt_ok_ff;
   logic      rsp_valid_ff;
   logic [7:0] rsp_byte_ff;
   logic      rsp_last_ff;

   logic      pos_zero;
   logic      hit_nxt;
   logic      out_free;
   logic      promote;
   logic      need_head;
   logic      need_pref;
   word_type  dem_ctr;
   word_type  ks_word;
   logic [7:0] ks_byte;

   cc20_core #(
      .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .ctrl      (gen_ctrl),
      .status    (gen_status),
      .block_out (gen_block)
   );

   always_comb begin
      pos_zero = (head.pos == '0);
      hit_nxt  = nxt_ok_ff && (nxt_tag_ff == head.ctr);
      out_free = !rsp_valid_ff || rsp_ready;
      head_pop = head_valid && (!pos_zero || hit_nxt) && out_free;
      promote  = head_pop && pos_zero;

      ks_word = cur_ff[head.pos[5:2]];
      ks_byte = pos_zero ? nxt_ff[0][7:0] : ks_word[{head.pos[1:0], 3'b000} +: 8];

      // a block boundary at the head has priority over the prefetch
      need_head = head_valid && pos_zero && !hit_nxt;
      need_pref = !nxt_ok_ff && cur_valid_ff;
      dem_ctr   = need_head ? head.ctr : cur_tag_ff + 32'd1;

      gen_ctrl.abort = cfg_wr;
      gen_ctrl.ctr   = dem_ctr;
      gen_ctrl.start = (need_head || need_pref) && !cfg_wr &&
                       !(gen_status.busy && (gen_status.ctr == dem_ctr));
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_last_out = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         nxt_ok_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= head_pop || (rsp_valid_ff && !rsp_ready);
         if (promote) begin
            cur_valid_ff <= 1'b1;
         end
         if (cfg_wr) begin
            nxt_ok_ff <= 1'b0;
         end else if (gen_status.done) begin
            nxt_ok_ff <= 1'b1;
         end else if (promote) begin
            nxt_ok_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (head_pop) begin
         rsp_byte_ff <= head.data_byte ^ ks_byte;
         rsp_last_ff <= head.end_of_message;
      end
      if (promote) begin
         cur_ff     <= nxt_ff;
         cur_tag_ff <= nxt_tag_ff;
      end
      if (gen_status.done) begin
         nxt_ff     <= gen_block;
         nxt_tag_ff <= gen_status.ctr;
      end
   end

   `CC20_ASSERT_NEXT(a_cfg_drops_nxt, clock, reset, cfg_wr, !nxt_ok_ff, "config write kept a stale block")
   `CC20_ASSERT_NEVER(a_done_vs_promote, clock, reset, gen_status.done && promote, "block done while promoting")
   `CC20_ASSERT_IMPLY(a_mid_block_cur, clock, reset, head_pop && !pos_zero, cur_valid_ff, "mid-block byte without a block")
   `CC20_ASSERT_NEXT(a_start_runs, clock, reset, gen_ctrl.start, gen_status.busy, "generator failed to start")

endmodule

[rtl/chacha20_stream_cipher_core.sv]
// Top level of the ChaCha20 byte-stream cipher core with its CSR block.
//
//   channel | prefix | direction | carries
//   --------+--------+-----------+------------------------------------------
//   request | req_   | in        | data_byte, end_of_message (valid/ready)
//   result  | rsp_   | out       | out_byte, last_out (valid/ready)
//   config  | csr_   | in/out    | 64-bit APB-style registers at 8*index
//
// Sustained rate is one byte per cycle while keystream is ready and rsp_ready
// holds; a byte passes the request queue, then the result register. A 64-byte
// keystream block is built in the single round unit (half a quarter round on
// all four lanes per cycle, then feed-forward), and the next block is
// prefetched while the current one is used. The first byte of a message whose
// counter block is not already waiting stalls until it is built; a CSR write
// drops the prefetched block. Reset is synchronous, needs no clearing pass,
// and the request queue absorbs result-side stalls for four requests.
module chacha20_stream_cipher_core #(
   parameter int DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [7:0]                        req_data_byte,
   input  logic                              req_end_of_message,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [7:0]                        rsp_out_byte,
   output logic                              rsp_last_out,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [cc20_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [cc20_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [cc20_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import cc20_pkg::*;

   // register index, taken from paddr above the byte offset
   localparam logic [2:0] CSR_KEY01    = 3'd0;
   localparam logic [2:0] CSR_KEY23    = 3'd1;
   localparam logic [2:0] CSR_KEY45    = 3'd2;
   localparam logic [2:0] CSR_KEY67    = 3'd3;
   localparam logic [2:0] CSR_NONCE01  = 3'd4;
   localparam logic [2:0] CSR_NONCE2   = 3'd5;
   localparam logic [2:0] CSR_INIT_CTR = 3'd6;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       cfg_wr;
   logic [2:0] csr_idx;

   logic       q_push;
   item_type   q_push_item;
   logic       q_pop;
   logic       q_full;
   logic       q_empty;
   item_type   q_head;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:3];
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite;

   // CSR writes; an index past the last register is ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_wr) begin
         case (csr_idx)
            CSR_KEY01: begin
               cfg_in.key[0] = csr_pwdata[31:0];
               cfg_in.key[1] = csr_pwdata[63:32];
            end
            CSR_KEY23: begin
               cfg_in.key[2] = csr_pwdata[31:0];
               cfg_in.key[3] = csr_pwdata[63:32];
            end
            CSR_KEY45: begin
               cfg_in.key[4] = csr_pwdata[31:0];
               cfg_in.key[5] = csr_pwdata[63:32];
            end
            CSR_KEY67: begin
               cfg_in.key[6] = csr_pwdata[31:0];
               cfg_in.key[7] = csr_pwdata[63:32];
            end
            CSR_NONCE01: begin
               cfg_in.nonce[0] = csr_pwdata[31:0];
               cfg_in.nonce[1] = csr_pwdata[63:32];
            end
            CSR_NONCE2: begin
               cfg_in.nonce[2] = csr_pwdata[31:0];
            end
            CSR_INIT_CTR: begin
               cfg_in.init_ctr = csr_pwdata[31:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // CSR readback
   always_comb begin
      case (csr_idx)
         CSR_KEY01:    csr_prdata = {cfg_ff.key[1], cfg_ff.key[0]};
         CSR_KEY23:    csr_prdata = {cfg_ff.key[3], cfg_ff.key[2]};
         CSR_KEY45:    csr_prdata = {cfg_ff.key[5], cfg_ff.key[4]};
         CSR_KEY67:    csr_prdata = {cfg_ff.key[7], cfg_ff.key[6]};
         CSR_NONCE01:  csr_prdata = {cfg_ff.nonce[1], cfg_ff.nonce[0]};
         CSR_NONCE2:   csr_prdata = {32'd0, cfg_ff.nonce[2]};
         CSR_INIT_CTR: csr_prdata = {32'd0, cfg_ff.init_ctr};
         default:      csr_prdata = '0;
      endcase
   end

   // front: classify each request (position, counter) and queue it
   cc20_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_end_of_message (req_end_of_message),
      .init_ctr           (cfg_ff.init_ctr),
      .full               (q_full),
      .push               (q_push),
      .item               (q_push_item)
   );

   cc20_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .pop       (q_pop),
      .full      (q_full),
      .empty     (q_empty),
      .head      (q_head)
   );

   // back: keystream generation, XOR and result register
   cc20_back #(
      .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .cfg_wr       (cfg_wr),
      .head_valid   (!q_empty),
      .head         (q_head),
      .head_pop     (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last_out (rsp_last_out)
   );

endmodule
